// ===== hw/rtl/ows_pkg.sv =====
// Shared types and codes for the 1-Wire Search ROM decision logic.
`timescale 1ns / 1ps

package ows_pkg;

    localparam logic [1:0] OP_NEW_SEARCH = 2'd0;
    localparam logic [1:0] OP_PASS_START = 2'd1;
    localparam logic [1:0] OP_BIT_PAIR   = 2'd2;

    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FAIL  = 2'd2;

    localparam logic [6:0] ROM_BITS_END = 7'd65;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    typedef struct packed {
        logic [63:0] code_bits;
        logic [6:0]  last_discrepancy;
        logic        search_done;
        logic [6:0]  bit_position;
        logic [6:0]  zero_pick_marker;
        logic [7:0]  crc_accumulator;
        logic        pass_active;
    } t_search_state;

    typedef struct packed {
        logic [1:0] operation;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } t_item;

    typedef struct packed {
        logic        direction;
        logic [1:0]  status;
        logic [63:0] rom_code;
        logic        last_device;
    } t_result;

    localparam t_search_state STATE_RESET = '{
        code_bits:        64'd0,
        last_discrepancy: 7'd0,
        search_done:      1'b0,
        bit_position:     7'd1,
        zero_pick_marker: 7'd0,
        crc_accumulator:  8'd0,
        pass_active:      1'b0
    };

endpackage

// ===== hw/rtl/onewire_rom_search.sv =====
// Top level of the 1-Wire Search ROM decision block.
//
// Input channel: i_valid / o_stall with i_operation, i_presence, i_id_bit,
// i_complement_bit. A transfer happens on a rising edge with i_valid high
// and o_stall low.
// Output channel: o_valid / i_stall with o_direction, o_status, o_rom_code,
// o_last_device. Exactly one result per input item, in order.
// Timing: an accepted item lands in the input register, then its result is
// computed combinationally and loaded into the output register, where o_valid
// rises; a stalled output register can keep the item waiting in between.
// Throughput: one item per cycle unless stalled; the search state update is a
// single pass of the decision logic between the input and output registers.
// When the receiver stalls, the output register holds its result and one more
// item may wait in the input register; o_stall rises only when both are full.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// search state to: no pass active, no history, bit position one.
`timescale 1ns / 1ps

module onewire_rom_search
    import ows_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic        i_presence,
    input  logic        i_id_bit,
    input  logic        i_complement_bit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_direction,
    output logic [1:0]  o_status,
    output logic [63:0] o_rom_code,
    output logic        o_last_device
);

    t_search_state r_state;
    t_search_state n_state;
    t_item         r_item;
    logic          r_item_valid;
    t_result       r_out;
    t_result       n_out;
    logic          r_out_valid;
    logic          out_load;
    logic          in_take;

    ows_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign out_load = r_item_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_item_valid && !out_load;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= STATE_RESET;
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_state <= n_state;
            end
            if (in_take) begin
                r_item_valid <= 1'b1;
            end else if (out_load) begin
                r_item_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= '{operation: i_operation, presence: i_presence,
                        id_bit: i_id_bit, complement_bit: i_complement_bit};
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_direction   = r_out.direction;
    assign o_status      = r_out.status;
    assign o_rom_code    = r_out.rom_code;
    assign o_last_device = r_out.last_device;

endmodule

// ===== hw/rtl/ows_step.sv =====
// Next-state and result logic for one search item.
`timescale 1ns / 1ps

module ows_step
    import ows_pkg::*;
(
    input  t_search_state i_state,
    input  t_item         i_item,
    output t_search_state o_state,
    output t_result       o_result
);

    logic [6:0] m;
    logic [5:0] idx;
    logic       g;
    logic [6:0] m_next;
    logic [6:0] marker;
    logic [7:0] crc_shift;
    logic [7:0] crc_new;
    logic [63:0] code_new;

    always_comb begin
        m         = i_state.bit_position;
        idx       = m[5:0] - 6'd1;
        marker    = i_state.zero_pick_marker;
        if (i_item.id_bit || i_item.complement_bit) begin
            g = i_item.id_bit;
        end else begin
            if (m < i_state.last_discrepancy) begin
                g = i_state.code_bits[idx];
            end else begin
                g = (m == i_state.last_discrepancy);
            end
            if (!g) begin
                marker = m;
            end
        end
        code_new      = i_state.code_bits;
        code_new[idx] = g;
        crc_shift     = {1'b0, i_state.crc_accumulator[7:1]};
        crc_new       = (i_state.crc_accumulator[0] ^ g) ? (crc_shift ^ CRC_POLY) : crc_shift;
        m_next        = m + 7'd1;
    end

    always_comb begin
        o_state  = i_state;
        o_result = '{direction: 1'b0, status: STATUS_BUSY, rom_code: 64'd0,
                     last_device: 1'b0};
        unique case (i_item.operation)
            OP_NEW_SEARCH: begin
                o_state.last_discrepancy = 7'd0;
                o_state.search_done      = 1'b0;
                o_state.pass_active      = 1'b0;
            end
            OP_PASS_START: begin
                o_state.crc_accumulator = 8'd0;
                if (!i_item.presence || i_state.search_done) begin
                    o_state.last_discrepancy = 7'd0;
                    o_state.pass_active      = 1'b0;
                    o_result.status          = STATUS_FAIL;
                end else begin
                    o_state.pass_active      = 1'b1;
                    o_state.bit_position     = 7'd1;
                    o_state.zero_pick_marker = 7'd0;
                end
            end
            OP_BIT_PAIR: begin
                if (i_state.pass_active) begin
                    if ((i_item.id_bit && i_item.complement_bit) || m == 7'd0
                        || m >= ROM_BITS_END) begin
                        o_state.last_discrepancy = 7'd0;
                        o_state.pass_active      = 1'b0;
                        o_result.status          = STATUS_FAIL;
                    end else begin
                        o_state.code_bits        = code_new;
                        o_state.zero_pick_marker = marker;
                        o_state.crc_accumulator  = crc_new;
                        o_state.bit_position     = m_next;
                        o_result.direction       = g;
                        if (m_next == ROM_BITS_END) begin
                            o_state.pass_active = 1'b0;
                            if (crc_new != 8'd0) begin
                                o_state.last_discrepancy = 7'd0;
                                o_result.status          = STATUS_FAIL;
                            end else begin
                                o_state.last_discrepancy = marker;
                                o_state.search_done      = (marker == 7'd0);
                                o_result.status          = STATUS_FOUND;
                                o_result.last_device     = (marker == 7'd0);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.rom_code = o_state.code_bits;
    end

endmodule
